// File: hdl/tpa_pkg.sv
package tpa_pkg;

    localparam int unsigned VTX_W = 32;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // topology codes
    localparam logic [1:0] TOPO_LIST = 2'd0;
    localparam logic [1:0] TOPO_STRIP = 2'd1;

    // index format codes
    localparam logic [1:0] FMT_IDX16 = 2'd0;
    localparam logic [1:0] FMT_IDX32 = 2'd1;
    localparam logic [1:0] FMT_NONE = 2'd2;

    // gathered vertex count codes
    localparam logic [1:0] GATHER_NONE = 2'd0;
    localparam logic [1:0] GATHER_ONE = 2'd1;
    localparam logic [1:0] GATHER_TWO = 2'd2;

    typedef enum logic [1:0] {
        CFG_TOPOLOGY     = 2'd0,
        CFG_INDEX_FORMAT = 2'd1,
        CFG_START_POS    = 2'd2,
        CFG_VERTEX_COUNT = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [1:0]       topology;
        logic [1:0]       index_format;
        logic [VTX_W-1:0] start_position;
        logic [VTX_W-1:0] vertex_count;
    } t_cfg;

    typedef struct packed {
        logic [VTX_W-1:0] corner_a;
        logic [VTX_W-1:0] corner_b;
        logic [VTX_W-1:0] corner_c;
        logic             range_error;
    } t_face;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

// File: hdl/tpa_front.sv
module tpa_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tpa_pkg::t_cfg               i_cfg,
    input  logic                        i_accept,
    input  logic [tpa_pkg::VTX_W-1:0]   i_index_value,
    input  logic                        i_group_end,
    output logic                        o_push,
    output tpa_pkg::t_face              o_face
);

    logic [tpa_pkg::VTX_W-1:0] r_pos, n_pos;
    logic [tpa_pkg::VTX_W-1:0] r_held_first, n_held_first;
    logic [tpa_pkg::VTX_W-1:0] r_held_second, n_held_second;
    logic [1:0]                r_count, n_count;
    logic                      r_parity, n_parity;
    logic                      r_failed, n_failed;

    logic [tpa_pkg::VTX_W-1:0] vtx;
    logic                      active;
    logic                      emit;
    logic                      bad;

    always_comb begin
        case (i_cfg.index_format)
            tpa_pkg::FMT_IDX16: vtx = {16'd0, i_index_value[15:0]};
            tpa_pkg::FMT_IDX32: vtx = i_index_value;
            default:            vtx = r_pos;
        endcase
    end

    assign active = !r_failed && (r_pos >= i_cfg.start_position)
                    && ((i_cfg.topology == tpa_pkg::TOPO_LIST)
                        || (i_cfg.topology == tpa_pkg::TOPO_STRIP));
    assign emit = active && (r_count == tpa_pkg::GATHER_TWO);
    assign bad = (r_held_first >= i_cfg.vertex_count)
                 || (r_held_second >= i_cfg.vertex_count)
                 || (vtx >= i_cfg.vertex_count);

    assign o_push = i_accept && emit;
    assign o_face = '{corner_a: r_held_first, corner_b: r_held_second,
                      corner_c: vtx, range_error: bad};

    always_comb begin
        n_pos         = r_pos;
        n_held_first  = r_held_first;
        n_held_second = r_held_second;
        n_count       = r_count;
        n_parity      = r_parity;
        n_failed      = r_failed;
        if (i_accept) begin
            n_pos = r_pos + 32'd1;
            if (active) begin
                case (r_count)
                    tpa_pkg::GATHER_NONE: begin
                        n_held_first = vtx;
                        n_count      = tpa_pkg::GATHER_ONE;
                    end
                    tpa_pkg::GATHER_ONE: begin
                        n_held_second = vtx;
                        n_count       = tpa_pkg::GATHER_TWO;
                    end
                    default: begin
                        if (bad) n_failed = 1'b1;
                        if (i_cfg.topology == tpa_pkg::TOPO_LIST) begin
                            n_count = tpa_pkg::GATHER_NONE;
                        end else begin
                            if (!r_parity) n_held_first = vtx;
                            else           n_held_second = vtx;
                            n_parity = !r_parity;
                        end
                    end
                endcase
            end
            if (i_group_end) begin
                n_pos         = '0;
                n_held_first  = '0;
                n_held_second = '0;
                n_count       = tpa_pkg::GATHER_NONE;
                n_parity      = 1'b0;
                n_failed      = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= '0;
            r_held_first  <= '0;
            r_held_second <= '0;
            r_count       <= tpa_pkg::GATHER_NONE;
            r_parity      <= 1'b0;
            r_failed      <= 1'b0;
        end else begin
            r_pos         <= n_pos;
            r_held_first  <= n_held_first;
            r_held_second <= n_held_second;
            r_count       <= n_count;
            r_parity      <= n_parity;
            r_failed      <= n_failed;
        end
    end

endmodule

// File: hdl/tpa_queue.sv
module tpa_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  tpa_pkg::t_face        i_face,
    input  logic                  i_pop,
    output tpa_pkg::t_face        o_face,
    output tpa_pkg::t_queue_status o_status
);

    tpa_pkg::t_face                r_mem [tpa_pkg::QUEUE_DEPTH];
    logic [tpa_pkg::QPTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [tpa_pkg::QPTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [tpa_pkg::QCNT_W-1:0]    r_count, n_count;
    logic                          do_push;
    logic                          do_pop;

    assign o_status.full  = (r_count == tpa_pkg::QCNT_W'(tpa_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_face  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) n_wr_ptr = (r_wr_ptr == tpa_pkg::QPTR_W'(tpa_pkg::QUEUE_DEPTH - 1))
                                ? '0 : r_wr_ptr + 1'b1;
        if (do_pop)  n_rd_ptr = (r_rd_ptr == tpa_pkg::QPTR_W'(tpa_pkg::QUEUE_DEPTH - 1))
                                ? '0 : r_rd_ptr + 1'b1;
        if (do_push && !do_pop)      n_count = r_count + 1'b1;
        else if (!do_push && do_pop) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_face;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// File: hdl/tpa_back.sv
module tpa_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tpa_pkg::t_face              i_face,
    input  logic                        i_empty,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [tpa_pkg::VTX_W-1:0]   o_corner_a,
    output logic [tpa_pkg::VTX_W-1:0]   o_corner_b,
    output logic [tpa_pkg::VTX_W-1:0]   o_corner_c,
    output logic                        o_range_error
);

    logic           r_valid, n_valid;
    tpa_pkg::t_face r_face;
    logic           load;

    assign load  = !i_empty && (!r_valid || !i_stall);
    assign o_pop = load;

    always_comb begin
        n_valid = r_valid;
        if (load)          n_valid = 1'b1;
        else if (!i_stall) n_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else          r_valid <= n_valid;
    end

    // error faces carry zero corners
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_face.corner_a    <= i_face.range_error ? '0 : i_face.corner_a;
            r_face.corner_b    <= i_face.range_error ? '0 : i_face.corner_b;
            r_face.corner_c    <= i_face.range_error ? '0 : i_face.corner_c;
            r_face.range_error <= i_face.range_error;
        end
    end

    assign o_valid       = r_valid;
    assign o_corner_a    = r_face.corner_a;
    assign o_corner_b    = r_face.corner_b;
    assign o_corner_c    = r_face.corner_c;
    assign o_range_error = r_face.range_error;

endmodule

// File: hdl/triangle_primitive_assembly_top.sv
// The face that an index completes is written into the face queue at the accepting edge,
// and is then loaded from the queue into the output register while the output is not stalled.
// Throughput: one index per cycle, sustained; the input stalls only when the
// two-entry face queue is full because the output side is stalled.
// Reset (i_rst_n low, synchronous): assembly state and queue cleared, registers
// return to list topology, 32-bit indices, start 0, vertex count 0.
module triangle_primitive_assembly_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration write request
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [1:0]                  i_cfg_index,
    input  logic [tpa_pkg::VTX_W-1:0]   i_cfg_data,
    // index element request
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [tpa_pkg::VTX_W-1:0]   i_index_value,
    input  logic                        i_group_end,
    // face request
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [tpa_pkg::VTX_W-1:0]   o_corner_a,
    output logic [tpa_pkg::VTX_W-1:0]   o_corner_b,
    output logic [tpa_pkg::VTX_W-1:0]   o_corner_c,
    output logic                        o_range_error
);

    tpa_pkg::t_cfg          r_cfg, n_cfg;
    tpa_pkg::t_face         front_face;
    tpa_pkg::t_face         queue_face;
    tpa_pkg::t_queue_status queue_status;
    logic                   in_accept;
    logic                   push;
    logic                   pop;

    // Registers are always writable; the host must write them only while nothing
    // is in flight. The block itself does not enforce this.
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (tpa_pkg::t_cfg_reg'(i_cfg_index))
                tpa_pkg::CFG_TOPOLOGY:     n_cfg.topology       = i_cfg_data[1:0];
                tpa_pkg::CFG_INDEX_FORMAT: n_cfg.index_format   = i_cfg_data[1:0];
                tpa_pkg::CFG_START_POS:    n_cfg.start_position = i_cfg_data;
                tpa_pkg::CFG_VERTEX_COUNT: n_cfg.vertex_count   = i_cfg_data;
                default:                   n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.topology       <= tpa_pkg::TOPO_LIST;
            r_cfg.index_format   <= tpa_pkg::FMT_IDX32;
            r_cfg.start_position <= '0;
            r_cfg.vertex_count   <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Stall is the queue-full flag, decoded from the registered entry count, so a
    // full-rate stream never waits while the output side keeps draining.
    assign o_in_stall = queue_status.full;
    assign in_accept  = i_in_valid && !queue_status.full;

    // Front: vertex fetch, skip window, list/strip gathering, range check.
    tpa_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_accept      (in_accept),
        .i_index_value (i_index_value),
        .i_group_end   (i_group_end),
        .o_push        (push),
        .o_face        (front_face)
    );

    // Short face queue decouples assembly from output backpressure.
    tpa_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_face   (front_face),
        .i_pop    (pop),
        .o_face   (queue_face),
        .o_status (queue_status)
    );

    // Back: output register, error faces zeroed.
    tpa_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_face        (queue_face),
        .i_empty       (queue_status.empty),
        .o_pop         (pop),
        .o_valid       (o_out_valid),
        .i_stall       (i_out_stall),
        .o_corner_a    (o_corner_a),
        .o_corner_b    (o_corner_b),
        .o_corner_c    (o_corner_c),
        .o_range_error (o_range_error)
    );

endmodule
